FILE: rtl/ascii_number_parser_core_assert.svh
// Assertion macros used by the checker file of the ASCII number parser.
`ifndef ASCII_NUMBER_PARSER_CORE_ASSERT_SVH
`define ASCII_NUMBER_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and off while i_rst_n is low.
`define ANP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ascii_number_parser_core: assertion failed");

// Next-cycle implication, sampled on i_clk and off while i_rst_n is low.
`define ANP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ascii_number_parser_core: assertion failed");

`endif

FILE: rtl/anp_pkg.sv
// Package with the widths, codes and helper function of the ASCII number parser.
`default_nettype none
package anp_pkg;

    localparam int CH_W    = 8;
    localparam int VALUE_W = 64;
    localparam int MODE_W  = 2;
    localparam int CNT_W   = 5;
    localparam int DIGIT_W = 4;

    localparam logic [CNT_W-1:0] HEX_MAX_DIGITS = CNT_W'(16);

    localparam logic [MODE_W-1:0] MODE_UNSIGNED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_OPTIONAL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SIGNED   = 2'd2;

    localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CH_W-1:0] CH_LOWER_F = 8'h66;
    localparam logic [CH_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CH_W-1:0] CH_UPPER_F = 8'h46;
    localparam logic [CH_W-1:0] CH_LOWER_X = 8'h78;
    localparam logic [CH_W-1:0] CH_UPPER_X = 8'h58;
    localparam logic [CH_W-1:0] CH_MINUS   = 8'h2d;

    typedef struct packed {
        logic               hit;
        logic [DIGIT_W-1:0] val;
    } t_digit;

    // Decodes one hexadecimal character of either case.
    function automatic t_digit hex_digit(input logic [CH_W-1:0] c);
        t_digit r;
        r.hit = 1'b1;
        r.val = c[DIGIT_W-1:0];
        if (c >= CH_ZERO && c <= CH_NINE) begin
            r.val = c[DIGIT_W-1:0];
        end else if ((c >= CH_LOWER_A && c <= CH_LOWER_F) ||
                     (c >= CH_UPPER_A && c <= CH_UPPER_F)) begin
            r.val = DIGIT_W'(c[2:0] + 3'd1) + DIGIT_W'(8);
        end else begin
            r.hit = 1'b0;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/anp_in_if.sv
// Character channel of the ASCII number parser.
`default_nettype none
interface anp_in_if;
    import anp_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;
    logic            last;
    logic            empty_token;

    modport source (output valid, ch, last, empty_token, input ready);
    modport sink (input valid, ch, last, empty_token, output ready);
endinterface
`default_nettype wire

FILE: rtl/anp_out_if.sv
// Result channel of the ASCII number parser.
`default_nettype none
interface anp_out_if;
    import anp_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               ok;
    logic               present;

    modport source (output valid, value, ok, present, input ready);
    modport sink (input valid, value, ok, present, output ready);
endinterface
`default_nettype wire

FILE: rtl/ascii_number_parser_core.sv
// Top level of the ASCII number parser: character stream in, one integer per token out.
//
// Characters of a token arrive on i_in, one per transfer, with last set on the final
// character; a transfer with empty_token set stands for a zero-length token.
// Each token end gives one transfer on o_out with value, ok and present.
// i_cfg_we writes the two-bit parse mode and drops any token in progress; the user
// writes it only while the block is idle, which the block itself does not enforce.
// A character is held in an input register and then goes through one decimal
// multiply-by-ten-and-add or hex shift into the token state; the result of a token
// is registered in the output register and from there appears on o_out.
// Throughput is one character per cycle while o_out is not stalled.
// While o_out is stalled with a result waiting, the input register can still
// take one character; further characters wait until the result is taken.
// Synchronous reset empties both registers, selects unsigned mode and clears
// the token state.
`default_nettype none
module ascii_number_parser_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [anp_pkg::MODE_W-1:0] i_cfg_data,
    anp_in_if.sink                          i_in,
    anp_out_if.source                       o_out
);
    import anp_pkg::*;

    typedef enum logic [2:0] {
        PH_START,
        PH_ZERO,
        PH_PREFIX,
        PH_HEX,
        PH_DEC,
        PH_MINUS
    } t_phase;

    logic [MODE_W-1:0]  r_mode;
    logic               r_in_valid;
    logic [CH_W-1:0]    r_ch;
    logic               r_last;
    logic               r_empty;

    logic [VALUE_W-1:0] r_acc, n_acc;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    t_phase             r_phase, n_phase;
    logic               r_failed, n_failed;
    logic               r_neg, n_neg;

    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_ok;
    logic               r_out_present;

    logic                   advance;
    logic                   is_signed;
    logic                   is_dig;
    logic [VALUE_W+3:0]     dec_sum;
    logic                   dec_fail;
    t_digit                 hex;
    logic                   res_ok;
    logic                   in_range;
    logic [VALUE_W-1:0]     res_val;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign is_signed  = (r_mode == MODE_SIGNED);

    assign is_dig   = (r_ch >= CH_ZERO) && (r_ch <= CH_NINE);
    assign dec_sum  = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                    + (VALUE_W+4)'(r_ch[DIGIT_W-1:0]);
    assign dec_fail = !is_dig || (|dec_sum[VALUE_W+3:VALUE_W]);
    assign hex      = hex_digit(r_ch);

    always_comb begin
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_phase  = r_phase;
        n_failed = r_failed;
        n_neg    = r_neg;
        if (!r_failed) begin
            case (r_phase)
                PH_START: begin
                    if (is_signed && r_ch == CH_MINUS) begin
                        n_neg   = 1'b1;
                        n_phase = PH_MINUS;
                    end else if (!is_signed && r_ch == CH_ZERO) begin
                        n_phase = PH_ZERO;
                    end else begin
                        n_failed = dec_fail;
                        n_acc    = dec_fail ? r_acc : dec_sum[VALUE_W-1:0];
                        n_phase  = PH_DEC;
                    end
                end
                PH_ZERO: begin
                    if (r_ch == CH_LOWER_X || r_ch == CH_UPPER_X) begin
                        n_phase = PH_PREFIX;
                    end else begin
                        n_failed = dec_fail;
                        n_acc    = dec_fail ? r_acc : dec_sum[VALUE_W-1:0];
                        n_phase  = PH_DEC;
                    end
                end
                PH_PREFIX: begin
                    if (hex.hit) begin
                        n_acc   = VALUE_W'(hex.val);
                        n_cnt   = CNT_W'(1);
                        n_phase = PH_HEX;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                PH_HEX: begin
                    if (!hex.hit || r_cnt >= HEX_MAX_DIGITS) begin
                        n_failed = 1'b1;
                    end else begin
                        n_acc = {r_acc[VALUE_W-DIGIT_W-1:0], hex.val};
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end
                PH_MINUS: begin
                    n_failed = dec_fail;
                    n_acc    = dec_fail ? r_acc : dec_sum[VALUE_W-1:0];
                    n_phase  = PH_DEC;
                end
                default: begin
                    n_failed = dec_fail;
                    n_acc    = dec_fail ? r_acc : dec_sum[VALUE_W-1:0];
                end
            endcase
        end
    end

    always_comb begin
        if (!is_signed) begin
            in_range = 1'b1;
        end else if (n_neg) begin
            in_range = !n_acc[VALUE_W-1] || (n_acc[VALUE_W-2:0] == '0);
        end else begin
            in_range = !n_acc[VALUE_W-1];
        end
        res_ok  = !n_failed && ((n_phase == PH_HEX) ||
                  ((n_phase == PH_ZERO || n_phase == PH_DEC) && in_range));
        res_val = n_neg ? (~n_acc + VALUE_W'(1)) : n_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_UNSIGNED;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc       <= '0;
            r_cnt       <= '0;
            r_phase     <= PH_START;
            r_failed    <= 1'b0;
            r_neg       <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
                r_ch       <= i_in.ch;
                r_last     <= i_in.last;
                r_empty    <= i_in.empty_token;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                r_mode   <= i_cfg_data;
                r_acc    <= '0;
                r_cnt    <= '0;
                r_phase  <= PH_START;
                r_failed <= 1'b0;
                r_neg    <= 1'b0;
            end else if (advance) begin
                if (r_empty || r_last) begin
                    r_acc    <= '0;
                    r_cnt    <= '0;
                    r_phase  <= PH_START;
                    r_failed <= 1'b0;
                    r_neg    <= 1'b0;
                end else begin
                    r_acc    <= n_acc;
                    r_cnt    <= n_cnt;
                    r_phase  <= n_phase;
                    r_failed <= n_failed;
                    r_neg    <= n_neg;
                end
            end

            if (advance && (r_empty || r_last)) begin
                r_out_valid <= 1'b1;
                if (r_empty) begin
                    r_out_value   <= '0;
                    r_out_ok      <= (r_mode == MODE_OPTIONAL);
                    r_out_present <= 1'b0;
                end else begin
                    r_out_value   <= res_ok ? res_val : '0;
                    r_out_ok      <= res_ok;
                    r_out_present <= res_ok;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.value   = r_out_value;
    assign o_out.ok      = r_out_ok;
    assign o_out.present = r_out_present;

endmodule
`default_nettype wire

FILE: rtl/anp_checker.sv
// Port-level checker of the ASCII number parser and its bind to the top level.
`default_nettype none
`include "ascii_number_parser_core_assert.svh"
module anp_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [anp_pkg::VALUE_W-1:0] i_out_value,
    input wire logic                        i_out_ok,
    input wire logic                        i_out_present
);
    import anp_pkg::*;

    `ANP_ASSERT_NOW(a_fail_is_zero, i_out_valid && !i_out_ok, i_out_value == '0 && !i_out_present)
    `ANP_ASSERT_NOW(a_present_needs_ok, i_out_valid && i_out_present, i_out_ok)
    `ANP_ASSERT_NOW(a_empty_after_reset, $past(!i_rst_n), !i_out_valid)
    `ANP_ASSERT_NEXT(a_stall_holds, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_value))

endmodule

bind ascii_number_parser_core anp_checker u_anp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_value   (o_out.value),
    .i_out_ok      (o_out.ok),
    .i_out_present (o_out.present)
);
`default_nettype wire
